/* sv/iokvt_pkg.sv */
// Package: shared constants, payload structs and cell control types for the ordered table.
`timescale 1ns / 1ps
package iokvt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 5;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]              command;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0]        key_out;
        logic signed [VAL_W-1:0] value_out;
        logic                    found;
        logic                    rejected;
        logic [CNT_W-1:0]        entry_count;
        logic                    last;
    } t_out_item;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_COMPARE,
        OP_WRITE,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

    // Contents that one cell hands to its neighbor
    typedef struct packed {
        logic                    valid;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_cell_data;

endpackage

/* sv/iokvt_cell.sv */
// One table cell: holds an entry, compares keys and shifts or rotates with its neighbors.
`timescale 1ns / 1ps
module iokvt_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  iokvt_pkg::t_cell_ctl  i_ctl,
    input  iokvt_pkg::t_cell_data i_next,
    input  iokvt_pkg::t_cell_data i_head,
    input  logic                  i_prev_valid,
    input  logic                  i_kill,
    output iokvt_pkg::t_cell_data o_data,
    output logic                  o_match,
    output logic                  o_kill
);
    import iokvt_pkg::*;

    logic                    r_valid;
    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_match;

    // Control state: valid mark and compare result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            case (i_ctl.op)
                OP_COMPARE: r_match <= r_valid && (r_key == i_ctl.key);
                OP_INSERT: begin
                    if (!r_valid && i_prev_valid) begin
                        r_valid <= 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (i_kill || r_match) begin
                        r_valid <= i_next.valid;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: overwrite, append, close the gap, or rotate toward the head
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_WRITE: begin
                if (r_match) begin
                    r_value <= i_ctl.value;
                end
            end
            OP_INSERT: begin
                if (!r_valid && i_prev_valid) begin
                    r_key   <= i_ctl.key;
                    r_value <= i_ctl.value;
                end
            end
            OP_REMOVE: begin
                if (i_kill || r_match) begin
                    r_key   <= i_next.key;
                    r_value <= i_next.value;
                end
            end
            OP_ROTATE: begin
                if (r_valid) begin
                    if (i_next.valid) begin
                        r_key   <= i_next.key;
                        r_value <= i_next.value;
                    end else begin
                        r_key   <= i_head.key;
                        r_value <= i_head.value;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_data  = '{valid: r_valid, key: r_key, value: r_value};
    assign o_match = r_match;
    assign o_kill  = i_kill || r_match;

endmodule

/* sv/insertion_ordered_key_value_table_core.sv */
// Top level: command sequencer, output register and the chain of table cells.
`timescale 1ns / 1ps
// Insertion-ordered key-value table with 16 entries.
// Input channel (i_in_valid / o_in_stall / i_in_item) carries put, get,
// remove and list commands; output channel (o_out_valid / i_out_stall /
// o_out_item) returns results. A transfer happens when valid is high and
// stall is low.
// Entries sit in a row of cells in insertion order, oldest in cell 0.
// Put, get and remove run in two steps: the parallel key compare in
// every cell, then the update and the load of the output register. Each
// gives one result with last set; the next command is taken in the cycle
// that result is loaded. Remove closes the gap by shifting later cells
// down one place.
// List rotates the cell row one place per cycle while the output register
// is free and emits the head entry, one result per stored key (one empty
// result if the table is empty); the next command is taken once the
// sequencer is back in idle after the last result; the row ends in its
// original order. Reset clears all valid marks and the entry count.
// When the receiver stalls, the result waits in the output register and
// the sequencer stalls the next step until the register frees up; one new
// command may still be taken while a result waits.
module insertion_ordered_key_value_table_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  iokvt_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output iokvt_pkg::t_out_item o_out_item
);
    import iokvt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_LIST
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_value;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_left;
    logic                    r_out_valid;
    t_out_item               r_out;

    t_state                  n_state;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        n_left;
    logic                    n_out_valid;
    t_out_item               n_out;

    t_cell_ctl               w_ctl;
    t_cell_data              w_data [CAPACITY+1];
    logic                    w_kill [CAPACITY+1];
    logic [CAPACITY-1:0]     w_match;
    logic [CAPACITY-1:0]     w_valid_vec;
    logic                    w_found;
    logic signed [VAL_W-1:0] w_hit_value;
    logic                    w_out_free;
    logic                    w_in_fire;
    logic                    w_full;
    logic                    w_put_new;
    logic                    w_rm_hit;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count >= CNT_W'(CAPACITY));
    assign o_in_stall = !((r_state == S_IDLE) || ((r_state == S_EXEC) && w_out_free));
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_put_new  = (r_cmd == CMD_PUT) && !w_found && !w_full;
    assign w_rm_hit   = (r_cmd == CMD_REMOVE) && w_found;

    // Cell row: head in cell 0, an empty entry past the tail
    assign w_data[CAPACITY] = '0;
    assign w_kill[0]        = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic w_prev_valid;
            if (g == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_rest
                assign w_prev_valid = w_data[g-1].valid;
            end
            iokvt_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_next       (w_data[g+1]),
                .i_head       (w_data[0]),
                .i_prev_valid (w_prev_valid),
                .i_kill       (w_kill[g]),
                .o_data       (w_data[g]),
                .o_match      (w_match[g]),
                .o_kill       (w_kill[g+1])
            );
            assign w_valid_vec[g] = w_data[g].valid;
        end
    endgenerate

    // Select the value of the matching cell
    always_comb begin
        w_hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i]) begin
                w_hit_value = w_hit_value | w_data[i].value;
            end
        end
    end
    assign w_found = |w_match;

    // Drive the operation for all cells
    always_comb begin
        w_ctl = '{op: OP_HOLD, key: r_key, value: r_value};
        case (r_state)
            S_LOOKUP: w_ctl.op = OP_COMPARE;
            S_EXEC: begin
                if (w_out_free) begin
                    if (r_cmd == CMD_PUT) begin
                        if (w_found) begin
                            w_ctl.op = OP_WRITE;
                        end else if (!w_full) begin
                            w_ctl.op = OP_INSERT;
                        end
                    end else if ((r_cmd == CMD_REMOVE) && w_found) begin
                        w_ctl.op = OP_REMOVE;
                    end
                end
            end
            S_LIST: begin
                if (w_out_free && (r_left != '0)) begin
                    w_ctl.op = OP_ROTATE;
                end
            end
            default: ;
        endcase
    end

    // Sequencer next state and output register contents
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: ;
            S_LOOKUP: n_state = S_EXEC;
            S_EXEC: begin
                if (w_out_free) begin
                    if (w_put_new) begin
                        n_count = r_count + 1'b1;
                    end else if (w_rm_hit) begin
                        n_count = r_count - 1'b1;
                    end
                    n_out_valid       = 1'b1;
                    n_out.key_out     = r_key;
                    n_out.value_out   = ((r_cmd == CMD_GET) && w_found) ? w_hit_value : '0;
                    n_out.found       = w_found;
                    n_out.rejected    = (r_cmd == CMD_PUT) && !w_found && w_full;
                    n_out.entry_count = n_count;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.rejected    = 1'b0;
                    n_out.entry_count = r_count;
                    if (r_left == '0) begin
                        n_out.key_out   = '0;
                        n_out.value_out = '0;
                        n_out.found     = 1'b0;
                        n_out.last      = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_out.key_out   = w_data[0].key;
                        n_out.value_out = w_data[0].value;
                        n_out.found     = 1'b1;
                        n_out.last      = (r_left == CNT_W'(1));
                        n_left          = r_left - 1'b1;
                        if (r_left == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Take a new command
        if (w_in_fire) begin
            if (t_cmd'(i_in_item.command) == CMD_LIST) begin
                n_state = S_LIST;
                n_left  = n_count;
            end else begin
                n_state = S_LOOKUP;
            end
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    // Hold the accepted command
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd   <= t_cmd'(i_in_item.command);
            r_key   <= i_in_item.key;
            r_value <= i_in_item.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Entry count never exceeds the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Entry count tracks the number of occupied cells
    a_count_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("entry count differs from occupied cells");

    // Occupied cells form a gap-free run from the head
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec & (w_valid_vec + 1'b1)) == '0)
        else $error("gap in occupied cells");

    // Keys are unique, so at most one cell matches
    a_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matched");

    // List never emits more entries than are stored
    a_list_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_left <= r_count))
        else $error("list remainder above entry count");

endmodule
